FILE: rtl/core/humidity_hysteresis_controller_defines.svh
// ----------------------------------------------------------------------------
// Humidity hysteresis controller assertion macros
// Shared concurrent assertion wrappers for the controller RTL.
// ----------------------------------------------------------------------------
`ifndef HUMIDITY_HYSTERESIS_CONTROLLER_DEFINES_SVH
`define HUMIDITY_HYSTERESIS_CONTROLLER_DEFINES_SVH

// checked only while out of reset
`define HHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define HHC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/hhc_pkg.sv
// ----------------------------------------------------------------------------
// Humidity hysteresis controller package
// Types, register indexes and constants shared by the controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hhc_pkg;

  localparam int unsigned HUM_W  = 10;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned ERR_W  = 4;
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 16;

  localparam logic [ERR_W-1:0] ERR_SAT = '1;

  localparam logic [HUM_W-1:0]  SETPOINT_RST   = HUM_W'(500);
  localparam logic [HUM_W-1:0]  HYSTERESIS_RST = HUM_W'(5);
  localparam logic [TICK_W-1:0] IDLE_RST       = TICK_W'(1000);
  localparam logic [TICK_W-1:0] ACTUATE_RST    = TICK_W'(1000);
  localparam logic [ERR_W-1:0]  ERR_LIMIT_RST  = ERR_W'(5);

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_CHECK       = 3'd1,
    PH_DRY         = 3'd2,
    PH_SENSE_DRY   = 3'd3,
    PH_HUMID       = 3'd4,
    PH_SENSE_HUMID = 3'd5
  } phase_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_HYSTERESIS = 3'd1,
    CFG_IDLE       = 3'd2,
    CFG_ACTUATE    = 3'd3,
    CFG_ERR_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             command;
    logic [HUM_W-1:0] humidity_now;
  } in_t;

  typedef struct packed {
    logic       start_measure;
    logic       system_error;
    logic       drying;
    logic       humidifying;
    logic [2:0] phase_out;
  } out_t;

  typedef struct packed {
    logic [HUM_W-1:0]  setpoint;
    logic [HUM_W-1:0]  hysteresis;
    logic [TICK_W-1:0] idle_period;
    logic [TICK_W-1:0] actuate_period;
    logic [ERR_W-1:0]  error_limit;
  } cfg_t;

endpackage

FILE: rtl/core/hhc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Humidity hysteresis controller configuration registers
// Write-only register file holding setpoint, band, timing and error-limit settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hhc_cfg_regs
  import hhc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_addr_i,
  input  logic [CFG_DW-1:0] cfg_wdata_i,
  output cfg_t              cfg_o
);

  cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SETPOINT:   cfg_d.setpoint       = cfg_wdata_i[HUM_W-1:0];
        CFG_HYSTERESIS: cfg_d.hysteresis     = cfg_wdata_i[HUM_W-1:0];
        CFG_IDLE:       cfg_d.idle_period    = cfg_wdata_i[TICK_W-1:0];
        CFG_ACTUATE:    cfg_d.actuate_period = cfg_wdata_i[TICK_W-1:0];
        CFG_ERR_LIMIT:  cfg_d.error_limit    = cfg_wdata_i[ERR_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint       <= SETPOINT_RST;
      cfg_q.hysteresis     <= HYSTERESIS_RST;
      cfg_q.idle_period    <= IDLE_RST;
      cfg_q.actuate_period <= ACTUATE_RST;
      cfg_q.error_limit    <= ERR_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/hhc_core.sv
// ----------------------------------------------------------------------------
// Humidity hysteresis controller core
// Phase state machine, countdown, event latch and error counter; one tick per
// accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_hysteresis_controller_defines.svh"

module hhc_core
  import hhc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic accept_i,
  input  in_t  in_data_i,
  output out_t res_o
);

  phase_e            phase_d, phase_q;
  logic [TICK_W-1:0] tick_d, tick_q;
  logic              event_d, event_q;
  logic [HUM_W-1:0]  last_d, last_q;
  logic [HUM_W-1:0]  prior_d, prior_q;
  logic [ERR_W-1:0]  errc_d, errc_q;

  logic              event_now;
  logic              tick_zero;
  logic              above, below;
  logic              good_dry, good_humid;
  logic [ERR_W-1:0]  errc_inc;
  logic              start_measure, system_error;

  logic [HUM_W:0] hum_x, sp_x, hy_x, last_x;

  assign hum_x  = {1'b0, in_data_i.humidity_now};
  assign sp_x   = {1'b0, cfg_i.setpoint};
  assign hy_x   = {1'b0, cfg_i.hysteresis};
  assign last_x = {1'b0, last_q};

  // band and move compares, all kept unsigned by moving the subtrahend across
  assign above      = hum_x > (sp_x + hy_x);
  assign below      = (hum_x + hy_x) < sp_x;
  assign good_dry   = (hum_x + hy_x) < last_x;
  assign good_humid = hum_x > (last_x + hy_x);

  assign event_now = event_q | in_data_i.command;
  assign tick_zero = (tick_q == '0);
  assign errc_inc  = errc_q + ERR_W'(1);

  // next state
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    event_d = event_q;
    last_d  = last_q;
    prior_d = prior_q;
    errc_d  = errc_q;
    if (accept_i) begin
      event_d = event_now;
      unique case (phase_q) inside
        PH_IDLE, PH_DRY, PH_HUMID: begin
          if (tick_zero) begin
            unique case (phase_q)
              PH_IDLE: phase_d = PH_CHECK;
              PH_DRY:  phase_d = PH_SENSE_DRY;
              default: phase_d = PH_SENSE_HUMID;
            endcase
          end else begin
            tick_d = tick_q - TICK_W'(1);
          end
        end
        PH_CHECK, PH_SENSE_DRY, PH_SENSE_HUMID: begin
          if (event_now) begin
            prior_d = last_q;
            last_d  = in_data_i.humidity_now;
            event_d = 1'b0;
            if (above) begin
              if (phase_q == PH_SENSE_HUMID) begin
                phase_d = PH_CHECK;
              end else begin
                phase_d = PH_DRY;
                tick_d  = cfg_i.actuate_period;
              end
            end else if (below) begin
              if (phase_q == PH_SENSE_DRY) begin
                phase_d = PH_CHECK;
              end else begin
                phase_d = PH_HUMID;
                tick_d  = cfg_i.actuate_period;
              end
            end else begin
              phase_d = PH_IDLE;
              tick_d  = cfg_i.idle_period;
            end
            if (phase_q != PH_CHECK) begin
              if ((phase_q == PH_SENSE_DRY) ? good_dry : good_humid) begin
                errc_d = '0;
              end else if (errc_q != ERR_SAT) begin
                errc_d = errc_inc;
              end
            end
          end
        end
        default: begin
          // unused code: behaves as idle with an expired count
          phase_d = PH_CHECK;
          tick_d  = '0;
        end
      endcase
    end
  end

  // result outputs
  always_comb begin
    start_measure = 1'b0;
    system_error  = 1'b0;
    unique case (phase_q) inside
      PH_IDLE, PH_DRY, PH_HUMID: begin
        start_measure = tick_zero;
      end
      PH_CHECK, PH_SENSE_DRY, PH_SENSE_HUMID: begin
        if (event_now) begin
          start_measure = (above && (phase_q == PH_SENSE_HUMID)) ||
                          (!above && below && (phase_q == PH_SENSE_DRY));
          if (phase_q != PH_CHECK) begin
            system_error = !((phase_q == PH_SENSE_DRY) ? good_dry : good_humid) &&
                           (errc_q != ERR_SAT) && (errc_inc == cfg_i.error_limit);
          end
        end
      end
      default: begin
        start_measure = 1'b1;
      end
    endcase
  end

  assign res_o.start_measure = start_measure;
  assign res_o.system_error  = system_error;
  assign res_o.drying        = (phase_d == PH_DRY);
  assign res_o.humidifying   = (phase_d == PH_HUMID);
  assign res_o.phase_out     = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      event_q <= 1'b0;
      last_q  <= '0;
      prior_q <= '0;
      errc_q  <= '0;
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      event_q <= event_d;
      last_q  <= last_d;
      prior_q <= prior_d;
      errc_q  <= errc_d;
    end
  end

  `HHC_ASSERT(a_event_consumed, accept_i && event_now && (phase_q == PH_CHECK || phase_q == PH_SENSE_DRY || phase_q == PH_SENSE_HUMID) |=> !event_q, "sensing phase left event pending")
  `HHC_ASSERT(a_err_from_sense, accept_i && res_o.system_error |-> (phase_q == PH_SENSE_DRY || phase_q == PH_SENSE_HUMID), "error pulse outside sensing phase")
  `HHC_ASSERT(a_countdown, accept_i && (phase_q == PH_DRY || phase_q == PH_HUMID || phase_q == PH_IDLE) && !tick_zero |=> (phase_q == $past(phase_q)) && (tick_q == $past(tick_q) - TICK_W'(1)), "countdown did not step")

endmodule

FILE: rtl/core/hhc_out_buf.sv
// ----------------------------------------------------------------------------
// Humidity hysteresis controller result buffer
// Output register plus skid entry, so a request is taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "humidity_hysteresis_controller_defines.svh"

module hhc_out_buf
  import hhc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  out_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic out_valid_d, out_valid_q;
  logic skid_valid_d, skid_valid_q;
  out_t out_data_d, out_data_q;
  out_t skid_data_d, skid_data_q;
  logic pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (out_valid_q && !pop) begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end else begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `HHC_ASSERT_ALWAYS(a_skid_behind_out, !rst_ni || !skid_valid_q || out_valid_q, "skid entry held without output entry")
  `HHC_ASSERT(a_skid_moves_up, skid_valid_q && !out_stall_i |=> out_valid_q && (out_data_q == $past(skid_data_q)), "skid entry lost on drain")
  `HHC_ASSERT(a_push_lands, push_i && !out_valid_q && !skid_valid_q |=> out_valid_q && !skid_valid_q, "request into empty buffer not registered")

endmodule

FILE: rtl/core/humidity_hysteresis_controller.sv
// A result is registered into the output register, or into the skid entry while the output stalls.
// Throughput: one request per cycle while the result buffer is not full; the phase update never holds a request.
// A two-entry result buffer keeps input flowing while one result is stalled.
// Reset: asynchronous, active low; phase idle, counters and event latch cleared,
// registers at their default settings, result buffer empty.
// ----------------------------------------------------------------------------
// Humidity hysteresis controller
// Bang-bang humidity control with dead band, timed actuation and error check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module humidity_hysteresis_controller
  import hhc_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_AW-1:0]         cfg_addr_i,
  input  logic [CFG_DW-1:0]         cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  in_t                       in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output out_t                      out_data_o
);

  cfg_t cfg;
  out_t res;
  logic accept;
  logic full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  hhc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  hhc_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .res_o     (res)
  );

  hhc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// Humidity hysteresis controller testbench
// Drives tick requests with random idling on both sides and a long output
// hold-off, predicts every result from a per-request model of the control
// loop, and compares the results field by field in order. Register settings
// change between phases while the block is drained, ending with the longest periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import hhc_pkg::*;

  class humidity_scoreboard;
    logic [HUM_W-1:0]  setpoint;
    logic [HUM_W-1:0]  hysteresis;
    logic [TICK_W-1:0] idle_period;
    logic [TICK_W-1:0] actuate_period;
    logic [ERR_W-1:0]  error_limit;

    phase_e            phase;
    logic [TICK_W-1:0] ticks;
    bit                event_latched;
    logic [HUM_W-1:0]  last_hum;
    logic [HUM_W-1:0]  prior_hum;
    logic [ERR_W-1:0]  err_count;

    out_t        expected_q[$];
    int unsigned requests;
    int unsigned checked;
    int unsigned failures;
    int unsigned error_pulses;
    int unsigned saturated_hits;
    int unsigned band_returns;

    function new();
      setpoint       = SETPOINT_RST;
      hysteresis     = HYSTERESIS_RST;
      idle_period    = IDLE_RST;
      actuate_period = ACTUATE_RST;
      error_limit    = ERR_LIMIT_RST;
      phase          = PH_IDLE;
      ticks          = '0;
      event_latched  = 1'b0;
      last_hum       = '0;
      prior_hum      = '0;
      err_count      = '0;
    endfunction

    function void set_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] v);
      case (idx)
        CFG_SETPOINT:   setpoint       = v[HUM_W-1:0];
        CFG_HYSTERESIS: hysteresis     = v[HUM_W-1:0];
        CFG_IDLE:       idle_period    = v[TICK_W-1:0];
        CFG_ACTUATE:    actuate_period = v[TICK_W-1:0];
        CFG_ERR_LIMIT:  error_limit    = v[ERR_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit count_down(input phase_e nxt);
      if (ticks == '0) begin
        phase = nxt;
        return 1'b1;
      end
      ticks = ticks - 1'b1;
      return 1'b0;
    endfunction

    // returns the error pulse; want_up is the direction the actuator should push
    function bit judge_move(input bit want_up);
      int diff;
      bit good;
      diff = int'(last_hum) - int'(prior_hum);
      good = want_up ? (diff > int'(hysteresis)) : (diff < -int'(hysteresis));
      if (good) begin
        err_count = '0;
        return 1'b0;
      end
      if (err_count == ERR_SAT) begin
        saturated_hits++;
        return 1'b0;
      end
      err_count = err_count + 1'b1;
      return err_count == error_limit;
    endfunction

    function void note_request(input in_t r);
      int     hi;
      int     lo;
      int     h;
      phase_e from;
      out_t   o;
      o = '0;
      requests++;
      if (r.command) event_latched = 1'b1;
      hi = int'(setpoint) + int'(hysteresis);
      lo = int'(setpoint) - int'(hysteresis);
      if ((phase == PH_CHECK || phase == PH_SENSE_DRY || phase == PH_SENSE_HUMID) &&
          event_latched) begin
        from          = phase;
        prior_hum     = last_hum;
        last_hum      = r.humidity_now;
        event_latched = 1'b0;
        h             = int'(last_hum);
        if (h > hi) begin
          if (from == PH_SENSE_HUMID) begin
            phase           = PH_CHECK;
            o.start_measure = 1'b1;
          end else begin
            phase = PH_DRY;
            ticks = actuate_period;
          end
        end else if (h < lo) begin
          if (from == PH_SENSE_DRY) begin
            phase           = PH_CHECK;
            o.start_measure = 1'b1;
          end else begin
            phase = PH_HUMID;
            ticks = actuate_period;
          end
        end else begin
          if (from != PH_CHECK) band_returns++;
          phase = PH_IDLE;
          ticks = idle_period;
        end
        if (from == PH_SENSE_DRY) o.system_error = judge_move(1'b0);
        else if (from == PH_SENSE_HUMID) o.system_error = judge_move(1'b1);
      end else begin
        case (phase)
          PH_DRY:   o.start_measure = count_down(PH_SENSE_DRY);
          PH_HUMID: o.start_measure = count_down(PH_SENSE_HUMID);
          PH_IDLE:  o.start_measure = count_down(PH_CHECK);
          default: ;
        endcase
      end
      if (o.system_error) error_pulses++;
      o.drying      = (phase == PH_DRY);
      o.humidifying = (phase == PH_HUMID);
      o.phase_out   = phase;
      expected_q.push_back(o);
    endfunction

    function void compare_field(input string name, input logic [2:0] want,
                                input logic [2:0] got);
      if (want !== got) begin
        failures++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(input out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        failures++;
        $display("%0t: result with none expected, expected nothing, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("start_measure", want.start_measure, got.start_measure);
      compare_field("system_error", want.system_error, got.system_error);
      compare_field("drying", want.drying, got.drying);
      compare_field("humidifying", want.humidifying, got.humidifying);
      compare_field("phase_out", want.phase_out, got.phase_out);
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_AW-1:0]  cfg_addr_i  = CFG_SETPOINT;
  logic [CFG_DW-1:0]  cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  in_t                in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_t               out_data_o;

  humidity_scoreboard sb = new();
  bit                 calm = 1'b0;

  humidity_hysteresis_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_request(input in_t r);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_reg(idx, v);
  endtask

  task automatic load_settings(input int sp, input int hy, input int idl, input int act,
                               input int lim);
    write_reg(CFG_SETPOINT, CFG_DW'(sp));
    write_reg(CFG_HYSTERESIS, CFG_DW'(hy));
    write_reg(CFG_IDLE, CFG_DW'(idl));
    write_reg(CFG_ACTUATE, CFG_DW'(act));
    write_reg(CFG_ERR_LIMIT, CFG_DW'(lim));
    cfg_we_i <= 1'b0;
  endtask

  // mix of rail values, uniform, near-constant, band-edge and converging readings
  function automatic logic [HUM_W-1:0] pick_humidity(input logic [HUM_W-1:0] prev);
    int v;
    int sp;
    int hy;
    sp = int'(sb.setpoint);
    hy = int'(sb.hysteresis);
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = 1000;
      2, 3:    v = $urandom_range(1000);
      4, 5:    v = int'(prev) + int'($urandom_range(4)) - 2;
      6:       v = (int'(prev) > sp) ? int'(prev) - hy - 1 - int'($urandom_range(20))
                                     : int'(prev) + hy + 1 + int'($urandom_range(20));
      default: v = sp + int'($urandom_range(2 * hy + 4)) - hy - 2;
    endcase
    if (v < 0) v = 0;
    if (v > 1000) v = 1000;
    return v[HUM_W-1:0];
  endfunction

  task automatic run_random(input int n, input int event_pct);
    logic [HUM_W-1:0] prev;
    in_t              r;
    prev = sb.setpoint;
    for (int i = 0; i < n; i++) begin
      r.command      = ($urandom_range(99) < event_pct);
      r.humidity_now = pick_humidity(prev);
      prev           = r.humidity_now;
      send_request(r);
    end
  endtask

  task automatic run_directed();
    int   cmds[26] = '{0, 1, 0, 1, 0, 0, 0, 0, 1, 0, 0, 1, 1,
                       0, 0, 1, 0, 0, 1, 0, 0, 1, 1, 0, 0, 1};
    int   hums[26] = '{0, 1000, 0, 0, 1000, 0, 0, 0, 1000, 0, 0, 0, 500,
                       0, 0, 0, 0, 0, 494, 0, 0, 1000, 1000, 0, 0, 500};
    in_t  r;
    for (int i = 0; i < 26; i++) begin
      r.command      = cmds[i][0];
      r.humidity_now = hums[i][HUM_W-1:0];
      send_request(r);
    end
  endtask

  initial begin
    int hold_left;
    bit pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (!pressure_done && sb.checked >= 600) begin
        hold_left     = 250;
        pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(99) < 30);
      end
    end
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_settings(500, 5, 1, 1, 2);
    run_directed();
    drain();

    calm = 1'b1;
    load_settings(500, 5, 0, 0, 1);
    run_random(300, 40);
    drain();
    calm = 1'b0;

    load_settings(0, 1000, 3, 1, 15);
    run_random(300, 30);
    drain();

    load_settings(1000, 0, 2, 3, 15);
    run_random(300, 35);
    drain();

    load_settings(300, 20, 1, 1, 4);
    run_random(300, 35);
    drain();

    load_settings(700, 0, 65535, 65535, 7);
    run_random(230, 30);
    drain();

    sb.failures += sb.pending();
    $display("Checked %0d results for %0d tick requests over six register settings.",
             sb.checked, sb.requests);
    $display("Error pulses %0d, saturated error counts %0d, in-band returns after actuation %0d.",
             sb.error_pulses, sb.saturated_hits, sb.band_returns);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: humidity_hysteresis_controller.f
+incdir+rtl/core
rtl/core/hhc_pkg.sv
rtl/core/hhc_cfg_regs.sv
rtl/core/hhc_core.sv
rtl/core/hhc_out_buf.sv
rtl/core/humidity_hysteresis_controller.sv
sim/testbench.sv
